// ===== src/ami_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ami_pkg
// Shared types, constants and helpers for the affine 3x4 matrix inverse.
// ----------------------------------------------------------------------------
package ami_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int NUM_ELEMS  = 12;
   localparam int ADDR_W     = $clog2(NUM_ELEMS);
   localparam int DIV_STEPS  = 64;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      OUT_QUOT,
      OUT_TRANS,
      OUT_SING
   } out_sel_type;

   typedef struct packed {
      logic              ram_we;
      logic [ADDR_W-1:0] ram_addr;
      logic              opa_load;
      logic              opa_sel_q;
      logic              opb_load;
      logic              opb_sel_s;
      logic              mul_en;
      acc_op_type        acc_op;
      logic              sat_s;
      logic              det_add;
      logic              tacc_add;
      logic              first;
      logic              div_start;
      logic              emit;
      out_sel_type       out_sel;
      logic [3:0]        out_index;
      logic              out_last;
   } ami_cmd_type;

   typedef struct packed {
      logic det_zero;
      logic div_done;
      logic out_free;
   } ami_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > $signed(64'h0000_0000_7FFF_FFFF))
         r = 32'sh7FFF_FFFF;
      else if (v < $signed(64'hFFFF_FFFF_8000_0000))
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/ami_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ami_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ami_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 12
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/ami_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ami_div
// Signed 64/64 restoring divider, one quotient bit per cycle, quotient
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ami_div import ami_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic signed [63:0] divisor,
   output      logic               done,
   output      logic signed [31:0] quotient
);

   logic                 busy_ff, fin_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [63:0]          num_ff, den_ff, rem_ff;
   logic                 neg_ff;
   logic signed [31:0]   quo_ff;

   logic [64:0] rem_sh, diff;
   logic        ge;
   logic [63:0] rem_in;
   logic signed [31:0] sat_q;

   always_comb begin
      rem_sh = {rem_ff, num_ff[63]};
      ge     = rem_sh >= {1'b0, den_ff};
      diff   = rem_sh - {1'b0, den_ff};
      rem_in = ge ? diff[63:0] : rem_sh[63:0];
      // num_ff holds the quotient magnitude once all steps are done
      if (neg_ff) begin
         if ((|num_ff[63:32]) || (num_ff[31] && (|num_ff[30:0])))
            sat_q = 32'sh8000_0000;
         else
            sat_q = $signed(~num_ff[31:0] + 32'd1);
      end else begin
         if (|num_ff[63:31])
            sat_q = 32'sh7FFF_FFFF;
         else
            sat_q = $signed(num_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
            num_ff  <= dividend[63] ? 64'(-dividend) : dividend;
            den_ff  <= divisor[63] ? 64'(-divisor) : divisor;
            rem_ff  <= '0;
            neg_ff  <= dividend[63] ^ divisor[63];
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            num_ff <= {num_ff[62:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            quo_ff  <= sat_q;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/ami_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ami_datapath
// Element store, shared multiplier, accumulators, divider and output register.
// ----------------------------------------------------------------------------
module ami_datapath import ami_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ami_cmd_type        cmd,
   output      ami_stat_type       stat,
   input  wire logic signed [31:0] req_element_value,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_result_value,
   output      logic [3:0]         rsp_result_index,
   output      logic               rsp_singular,
   output      logic               rsp_last_result
);

   logic [31:0]        rdata;
   logic signed [31:0] opa_ff, opb_ff, s_ff;
   logic signed [63:0] prod_ff, acc_ff, det_ff, tacc_ff;
   logic signed [63:0] prod_fs;
   logic               div_done;
   logic signed [31:0] quot;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [3:0]         rsp_index_ff;
   logic               rsp_sing_ff, rsp_last_ff;

   ami_ram #(.WIDTH(32), .DEPTH(NUM_ELEMS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.ram_we),
      .wr_addr (cmd.ram_addr),
      .wr_data (req_element_value),
      .rd_addr (cmd.ram_addr),
      .rd_data (rdata)
   );

   ami_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (det_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign prod_fs = prod_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (cmd.opa_load) opa_ff <= cmd.opa_sel_q ? quot : $signed(rdata);
      if (cmd.opb_load) opb_ff <= cmd.opb_sel_s ? s_ff : $signed(rdata);
      if (cmd.mul_en)   prod_ff <= opa_ff * opb_ff;
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= prod_ff;
         ACC_SUB:  acc_ff <= acc_ff - prod_ff;
         default:  acc_ff <= acc_ff;
      endcase
      if (cmd.sat_s)    s_ff <= sat32(acc_ff >>> FRAC_BITS);
      if (cmd.det_add)  det_ff <= (cmd.first ? 64'sd0 : det_ff) + prod_fs;
      if (cmd.tacc_add) tacc_ff <= (cmd.first ? 64'sd0 : tacc_ff) + prod_fs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         case (cmd.out_sel)
            OUT_QUOT:  rsp_value_ff <= quot;
            OUT_TRANS: rsp_value_ff <= sat32(-tacc_ff);
            default:   rsp_value_ff <= 32'sd0;
         endcase
         rsp_index_ff <= cmd.out_index;
         rsp_sing_ff  <= (cmd.out_sel == OUT_SING);
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign stat.det_zero = (det_ff == 64'sd0);
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_singular     = rsp_sing_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== src/ami_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ami_ctrl
// Sequencer: loads elements, walks the minors, determinant, divisions and
// translation terms, and schedules the result transfers.
// ----------------------------------------------------------------------------
module ami_ctrl import ami_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   output      ami_cmd_type  cmd,
   input  wire ami_stat_type stat
);

   typedef enum logic [3:0] {
      S_LOAD, S_RDA, S_RDB, S_LATB, S_MUL, S_ACC, S_SAT,
      S_CHK, S_DIV, S_DIVW, S_EMQ, S_EMT, S_EMS
   } state_type;

   typedef enum logic [1:0] {
      J_MINOR_DET, J_DET_TERM, J_MINOR_INV, J_TRANS
   } job_type;

   state_type         state_ff;
   job_type           job_ff;
   logic [ADDR_W-1:0] cnt_ff;
   logic [1:0]        r_ff, c_ff;
   logic              t_ff;

   logic [1:0]        r1, r2, c1, c2;
   logic [ADDR_W-1:0] addr_a, addr_b;

   function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   always_comb begin
      r1 = add_mod3(r_ff, 2'd1);
      r2 = add_mod3(r_ff, 2'd2);
      c1 = add_mod3(c_ff, 2'd1);
      c2 = add_mod3(c_ff, 2'd2);
      case (job_ff)
         J_DET_TERM: begin
            addr_a = {c_ff, 2'd0};
            addr_b = {c_ff, 2'd0};
         end
         J_TRANS: begin
            addr_a = {c_ff, 2'd3};
            addr_b = {c_ff, 2'd3};
         end
         default: begin
            addr_a = t_ff ? {c1, r2} : {c1, r1};
            addr_b = t_ff ? {c2, r1} : {c2, r2};
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.acc_op    = ACC_NONE;
      cmd.out_sel   = OUT_QUOT;
      cmd.first     = (c_ff == 2'd0);
      req_ready     = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready    = 1'b1;
            cmd.ram_we   = req_valid;
            cmd.ram_addr = cnt_ff;
         end
         S_RDA: cmd.ram_addr = addr_a;
         S_RDB: begin
            cmd.ram_addr  = addr_b;
            cmd.opa_load  = 1'b1;
            cmd.opa_sel_q = (job_ff == J_TRANS);
         end
         S_LATB: begin
            cmd.opb_load  = 1'b1;
            cmd.opb_sel_s = (job_ff == J_DET_TERM);
         end
         S_MUL: cmd.mul_en = 1'b1;
         S_ACC: begin
            case (job_ff)
               J_DET_TERM: cmd.det_add  = 1'b1;
               J_TRANS:    cmd.tacc_add = 1'b1;
               default:    cmd.acc_op   = t_ff ? ACC_SUB : ACC_LOAD;
            endcase
         end
         S_SAT: cmd.sat_s = 1'b1;
         S_DIV: cmd.div_start = 1'b1;
         S_EMQ: begin
            cmd.emit      = stat.out_free;
            cmd.out_sel   = OUT_QUOT;
            cmd.out_index = {r_ff, c_ff};
         end
         S_EMT: begin
            cmd.emit      = stat.out_free;
            cmd.out_sel   = OUT_TRANS;
            cmd.out_index = {r_ff, 2'd3};
            cmd.out_last  = (r_ff == 2'd2);
         end
         S_EMS: begin
            cmd.emit      = stat.out_free;
            cmd.out_sel   = OUT_SING;
            cmd.out_index = 4'd0;
            cmd.out_last  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         job_ff   <= J_MINOR_DET;
         cnt_ff   <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         t_ff     <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (cnt_ff == ADDR_W'(NUM_ELEMS - 1)) begin
                     cnt_ff   <= '0;
                     r_ff     <= '0;
                     c_ff     <= '0;
                     t_ff     <= 1'b0;
                     job_ff   <= J_MINOR_DET;
                     state_ff <= S_RDA;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            S_RDA:  state_ff <= S_RDB;
            S_RDB:  state_ff <= S_LATB;
            S_LATB: state_ff <= S_MUL;
            S_MUL:  state_ff <= S_ACC;
            S_ACC: begin
               case (job_ff)
                  J_DET_TERM: begin
                     if (c_ff == 2'd2) begin
                        state_ff <= S_CHK;
                     end else begin
                        c_ff     <= c_ff + 1'b1;
                        job_ff   <= J_MINOR_DET;
                        state_ff <= S_RDA;
                     end
                  end
                  J_TRANS: begin
                     if (c_ff == 2'd2) begin
                        state_ff <= S_EMT;
                     end else begin
                        c_ff     <= c_ff + 1'b1;
                        job_ff   <= J_MINOR_INV;
                        state_ff <= S_RDA;
                     end
                  end
                  default: begin
                     if (!t_ff) begin
                        t_ff     <= 1'b1;
                        state_ff <= S_RDA;
                     end else begin
                        t_ff     <= 1'b0;
                        state_ff <= (job_ff == J_MINOR_DET) ? S_SAT : S_DIV;
                     end
                  end
               endcase
            end
            S_SAT: begin
               job_ff   <= J_DET_TERM;
               state_ff <= S_RDA;
            end
            S_CHK: begin
               if (stat.det_zero) begin
                  state_ff <= S_EMS;
               end else begin
                  r_ff     <= '0;
                  c_ff     <= '0;
                  job_ff   <= J_MINOR_INV;
                  state_ff <= S_RDA;
               end
            end
            S_DIV:  state_ff <= S_DIVW;
            S_DIVW: if (stat.div_done) state_ff <= S_EMQ;
            S_EMQ: begin
               if (stat.out_free) begin
                  job_ff   <= J_TRANS;
                  state_ff <= S_RDA;
               end
            end
            S_EMT: begin
               if (stat.out_free) begin
                  if (r_ff == 2'd2) begin
                     state_ff <= S_LOAD;
                  end else begin
                     r_ff     <= r_ff + 1'b1;
                     c_ff     <= '0;
                     job_ff   <= J_MINOR_INV;
                     state_ff <= S_RDA;
                  end
               end
            end
            S_EMS: if (stat.out_free) state_ff <= S_LOAD;
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/affine_matrix_inverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Inverse of a 3x4 affine transform in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle in row-major order. Loading the twelfth
// element starts the compute; no element is taken until every result of that
// matrix has been queued. The determinant is formed first; each of the
// nine rotation entries then runs a 64-step shift-subtract divide plus a
// shared-multiplier pass, so the time per matrix is set by the bit-serial
// divider. A singular matrix gives one transfer with the singular flag
// set. A finished result waits in the output register without stalling
// the next load.
module affine_matrix_inverse import ami_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic signed [31:0] req_element_value,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_result_value,
   output      logic [3:0]         rsp_result_index,
   output      logic               rsp_singular,
   output      logic               rsp_last_result
);

   ami_cmd_type  cmd;
   ami_stat_type stat;

   ami_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ami_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_result_index  (rsp_result_index),
      .rsp_singular      (rsp_singular),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
`default_nettype wire

// ===== src/ami_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ami_port_checks
// Port-level checks for the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module ami_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result_value,
   input wire logic [3:0]  rsp_result_index,
   input wire logic        rsp_singular,
   input wire logic        rsp_last_result
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_result_index))
      else $error("result changed while stalled");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last_result && rsp_result_index == 4'd0
         && rsp_result_value == 32'd0)
      else $error("singular transfer malformed");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_index == 4'd11 |-> rsp_last_result && !rsp_singular)
      else $error("index 11 not marked last");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result |=> !rsp_valid
         || rsp_result_index == $past(rsp_result_index) + 4'd1)
      else $error("result index out of order");

endmodule

bind affine_matrix_inverse ami_port_checks u_ami_port_checks (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_result_index (rsp_result_index),
   .rsp_singular     (rsp_singular),
   .rsp_last_result  (rsp_last_result)
);
`default_nettype wire
